### hw/rtl/pcer_pkg.sv
package pcer_pkg;

    // Field and register widths
    localparam int TB_W       = 13;
    localparam int RC_W       = 16;
    localparam int ROW_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Shift-subtract unit: dividend / offset width and its step counter
    localparam int SRC_W = 19;
    localparam int CNT_W = 5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IS_REAL     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_BYTES  = 2'd3;

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // Result value types
    typedef logic [1:0] vtype_t;
    localparam vtype_t VT_INT  = 2'd0;
    localparam vtype_t VT_LONG = 2'd1;
    localparam vtype_t VT_F32  = 2'd2;
    localparam vtype_t VT_F64  = 2'd3;

    // Element width codes
    typedef logic [2:0] wcode_t;
    localparam wcode_t WC_NONE = 3'd0;
    localparam wcode_t WC_1    = 3'd1;
    localparam wcode_t WC_2    = 3'd2;
    localparam wcode_t WC_4    = 3'd3;
    localparam wcode_t WC_8    = 3'd4;
    localparam wcode_t WC_16   = 3'd5;
    localparam wcode_t WC_32   = 3'd6;
    localparam wcode_t WC_64   = 3'd7;

    // Small-vector width table, [row_count][total_bytes]
    localparam wcode_t WIDTH_TABLE [0:7][0:6] = '{
        '{WC_NONE, WC_NONE, WC_NONE, WC_NONE, WC_NONE, WC_NONE, WC_NONE},
        '{WC_NONE, WC_8,    WC_16,   WC_1,    WC_32,   WC_2,    WC_4   },
        '{WC_NONE, WC_4,    WC_8,    WC_1,    WC_16,   WC_2,    WC_NONE},
        '{WC_NONE, WC_2,    WC_4,    WC_8,    WC_1,    WC_NONE, WC_16  },
        '{WC_NONE, WC_2,    WC_4,    WC_NONE, WC_8,    WC_1,    WC_NONE},
        '{WC_NONE, WC_1,    WC_2,    WC_4,    WC_NONE, WC_8,    WC_NONE},
        '{WC_NONE, WC_1,    WC_2,    WC_4,    WC_NONE, WC_NONE, WC_8   },
        '{WC_NONE, WC_1,    WC_2,    WC_NONE, WC_4,    WC_NONE, WC_NONE}
    };

    // Quotient of bytes*8/rows to width code; anything unlisted is none
    function automatic wcode_t quot_to_code(input logic [SRC_W-1:0] q);
        wcode_t c;
        unique case (q)
            SRC_W'(1):  c = WC_1;
            SRC_W'(2):  c = WC_2;
            SRC_W'(4):  c = WC_4;
            SRC_W'(8):  c = WC_8;
            SRC_W'(16): c = WC_16;
            SRC_W'(32): c = WC_32;
            SRC_W'(64): c = WC_64;
            default:    c = WC_NONE;
        endcase
        return c;
    endfunction

    // Memory bytes touched per element
    function automatic logic [3:0] code_bytes(input wcode_t c);
        logic [3:0] n;
        unique case (c)
            WC_16:   n = 4'd2;
            WC_32:   n = 4'd4;
            WC_64:   n = 4'd8;
            default: n = 4'd1;
        endcase
        return n;
    endfunction

endpackage

### hw/rtl/packed_column_element_reader.sv
// Channel  | Dir | Signals                      | Contents
// ---------+-----+------------------------------+-----------------------------------------
// s_       | in  | s_tvalid s_tready s_tdata    | write byte / read element request
//          |     | s_tuser                      | kind (0 write, 1 read)
// m_       | out | m_tvalid m_tready m_tdata    | element value, one word per read
//          |     | m_tuser                      | found, value type
// cfg_     | in  | cfg_we cfg_index cfg_data    | total_bytes, row_count, is_real, flip
//
// Write: direct when MEM_BYTES is a power of two or >= 4096, else after a modulo pass (S_MOD).
// Read: states S_WRAP, S_BASE and S_FETCH, which reads nbytes (1, 2, 4 or 8, one memory read per cycle),
//   plus S_DIV for the shift-subtract divide when the width comes from bytes*8/rows,
//   plus S_MOD for the address modulo when MEM_BYTES is not a power of two.
// One item in flight; s_tready is high only while idle.
// A finished result sits in the output register; while m_ is stalled, a new one is held back in the sequencer.
// aresetn is synchronous, active low; memory contents are undefined until written.
module packed_column_element_reader
    import pcer_pkg::*;
#(
    parameter int MEM_BYTES = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // byte_address[11:0], byte_value[19:12],
                                             // row_index[35:20], zero pad[39:36]
    input  logic                  s_tuser,   // kind[0]

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,   // element_value[63:0]
    output logic [2:0]            m_tuser,   // found[0], value_type[2:1]

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW       = $clog2(MEM_BYTES);
    localparam bit MEM_POW2 = (MEM_BYTES == (1 << AW));
    localparam bit WR_DIRECT = MEM_POW2 || (MEM_BYTES >= 4096);
    localparam int UW       = (AW + 1 > RC_W + 1) ? AW + 1 : RC_W + 1;
    localparam int XW       = (AW > SRC_W) ? AW : SRC_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WRAP  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_BASE  = 3'd3;
    localparam logic [2:0] S_MOD   = 3'd4;
    localparam logic [2:0] S_FETCH = 3'd5;

    // input word fields
    logic              s_kind;
    logic [11:0]       s_byte_address;
    logic [7:0]        s_byte_value;
    logic [ROW_W-1:0]  s_row_index;

    assign s_kind         = s_tuser;
    assign s_byte_address = s_tdata[11:0];
    assign s_byte_value   = s_tdata[19:12];
    assign s_row_index    = s_tdata[35:20];

    // configuration
    logic [TB_W-1:0] tb_reg;
    logic [RC_W-1:0] rc_reg;
    logic            real_reg;
    logic            flip_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tb_reg   <= '0;
            rc_reg   <= '0;
            real_reg <= 1'b0;
            flip_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TOTAL_BYTES: tb_reg   <= cfg_data[TB_W-1:0];
                REG_ROW_COUNT:   rc_reg   <= cfg_data[RC_W-1:0];
                REG_IS_REAL:     real_reg <= cfg_data[0];
                REG_FLIP_BYTES:  flip_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // sequencer and datapath state
    logic [2:0]       state_reg, state_next;
    logic             kind_reg, kind_next;
    logic [7:0]       byte_reg, byte_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [RC_W-1:0]  r_reg, r_next;
    wcode_t           width_reg, width_next;
    logic [SRC_W-1:0] src_reg, src_next;
    logic [UW-1:0]    rem_reg, rem_next;
    logic [UW-1:0]    op_reg, op_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [3:0]       ic_reg, ic_next;
    logic [3:0]       cc_reg, cc_next;
    logic             pend_reg, pend_next;
    logic [63:0]      acc_reg, acc_next;

    // byte memory
    logic [7:0]    mem [MEM_BYTES];
    logic [7:0]    rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[addr_reg];
    end

    // output register
    logic        m_valid_reg;
    logic        m_found_reg;
    logic [63:0] m_value_reg;
    vtype_t      m_type_reg;
    logic        out_free;
    logic        emit;
    logic        res_found;
    logic [63:0] res_value;
    vtype_t      res_type;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = {m_type_reg, m_found_reg};

    // shared shift-subtract unit: one quotient bit per cycle, used for
    // bytes*8/rows and for address modulo MEM_BYTES
    logic [UW-1:0] ss_trial;
    logic          ss_ge;

    assign ss_trial = {rem_reg[UW-2:0], src_reg[SRC_W-1]};
    assign ss_ge    = (ss_trial >= op_reg);

    // row wrap and range check
    logic [RC_W+1:0] row_ext;
    logic [RC_W+1:0] row_wrap;
    logic            row_found;
    logic            table_hit;

    assign row_ext   = {{2{row_reg[ROW_W-1]}}, row_reg};
    assign row_wrap  = row_reg[ROW_W-1] ? (row_ext + {2'b00, rc_reg}) : row_ext;
    assign row_found = !row_wrap[RC_W+1] && (row_wrap[RC_W:0] < {1'b0, rc_reg});
    assign table_hit = (rc_reg < RC_W'(8)) && (tb_reg < TB_W'(7));

    // element byte offset, then cut to the memory address
    logic [SRC_W-1:0] r_ext;
    logic [SRC_W-1:0] elem_off;
    logic [XW-1:0]    off_x;
    logic [XW-1:0]    wa_x;

    assign r_ext = SRC_W'(r_reg);
    assign off_x = XW'(elem_off);
    assign wa_x  = XW'(s_byte_address);

    always_comb begin
        unique case (width_reg)
            WC_1:    elem_off = r_ext >> 3;
            WC_2:    elem_off = r_ext >> 2;
            WC_4:    elem_off = r_ext >> 1;
            WC_16:   elem_off = r_ext << 1;
            WC_32:   elem_off = r_ext << 2;
            WC_64:   elem_off = r_ext << 3;
            default: elem_off = r_ext;
        endcase
    end

    // byte gather position
    logic [3:0] nb;
    logic [3:0] pos_full;
    logic [2:0] pos;

    assign nb       = code_bytes(width_reg);
    assign pos_full = flip_reg ? (nb - 4'd1 - cc_reg) : cc_reg;
    assign pos      = pos_full[2:0];

    // final element formatting
    logic [7:0]  lo_byte;
    logic [7:0]  sh1;
    logic [7:0]  sh2;
    logic [7:0]  sh4;
    logic [63:0] fin_value;
    vtype_t      fin_type;

    assign lo_byte = acc_reg[7:0];
    assign sh1     = lo_byte >> r_reg[2:0];
    assign sh2     = lo_byte >> {r_reg[1:0], 1'b0};
    assign sh4     = lo_byte >> {r_reg[0], 2'b00};

    always_comb begin
        fin_value = '0;
        fin_type  = VT_INT;
        unique case (width_reg)
            WC_1:  fin_value = {63'd0, sh1[0]};
            WC_2:  fin_value = {62'd0, sh2[1:0]};
            WC_4:  fin_value = {60'd0, sh4[3:0]};
            WC_8:  fin_value = {{56{lo_byte[7]}}, lo_byte};
            WC_16: fin_value = {{48{acc_reg[15]}}, acc_reg[15:0]};
            WC_32: begin
                if (real_reg) begin
                    fin_value = {32'd0, acc_reg[31:0]};
                    fin_type  = VT_F32;
                end else begin
                    fin_value = {{32{acc_reg[31]}}, acc_reg[31:0]};
                end
            end
            WC_64: begin
                fin_value = acc_reg;
                fin_type  = real_reg ? VT_F64 : VT_LONG;
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        byte_next  = byte_reg;
        row_next   = row_reg;
        r_next     = r_reg;
        width_next = width_reg;
        src_next   = src_reg;
        rem_next   = rem_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        addr_next  = addr_reg;
        ic_next    = ic_reg;
        cc_next    = cc_reg;
        pend_next  = 1'b0;
        acc_next   = acc_reg;
        emit       = 1'b0;
        res_found  = 1'b0;
        res_value  = '0;
        res_type   = VT_INT;
        mem_we     = 1'b0;
        mem_waddr  = wa_x[AW-1:0];
        mem_wdata  = s_byte_value;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    kind_next = s_kind;
                    byte_next = s_byte_value;
                    row_next  = s_row_index;
                    if (s_kind == KIND_WRITE) begin
                        if (WR_DIRECT) begin
                            mem_we = 1'b1;
                        end else begin
                            src_next   = SRC_W'(s_byte_address);
                            rem_next   = '0;
                            op_next    = UW'(MEM_BYTES);
                            cnt_next   = CNT_W'(SRC_W);
                            state_next = S_MOD;
                        end
                    end else begin
                        state_next = S_WRAP;
                    end
                end
            end

            S_WRAP: begin
                r_next = row_wrap[RC_W-1:0];
                if (!row_found) begin
                    // nil result
                    if (out_free) begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                    end
                end else if (table_hit) begin
                    width_next = WIDTH_TABLE[rc_reg[2:0]][tb_reg[2:0]];
                    state_next = S_BASE;
                end else begin
                    src_next   = SRC_W'({tb_reg, 3'b000});
                    rem_next   = '0;
                    op_next    = UW'(rc_reg);
                    cnt_next   = CNT_W'(SRC_W);
                    state_next = S_DIV;
                end
            end

            S_DIV: begin
                if (cnt_reg != '0) begin
                    rem_next = ss_ge ? (ss_trial - op_reg) : ss_trial;
                    src_next = {src_reg[SRC_W-2:0], ss_ge};
                    cnt_next = cnt_reg - CNT_W'(1);
                end else begin
                    width_next = quot_to_code(src_reg);
                    state_next = S_BASE;
                end
            end

            S_BASE: begin
                acc_next = '0;
                ic_next  = '0;
                cc_next  = '0;
                if (width_reg == WC_NONE) begin
                    // unlisted width: found, zero value
                    if (out_free) begin
                        emit       = 1'b1;
                        res_found  = 1'b1;
                        state_next = S_IDLE;
                    end
                end else if (MEM_POW2) begin
                    addr_next  = off_x[AW-1:0];
                    state_next = S_FETCH;
                end else begin
                    src_next   = elem_off;
                    rem_next   = '0;
                    op_next    = UW'(MEM_BYTES);
                    cnt_next   = CNT_W'(SRC_W);
                    state_next = S_MOD;
                end
            end

            S_MOD: begin
                if (cnt_reg != '0) begin
                    rem_next = ss_ge ? (ss_trial - op_reg) : ss_trial;
                    src_next = {src_reg[SRC_W-2:0], ss_ge};
                    cnt_next = cnt_reg - CNT_W'(1);
                end else if (kind_reg == KIND_WRITE) begin
                    mem_we     = 1'b1;
                    mem_waddr  = rem_reg[AW-1:0];
                    mem_wdata  = byte_reg;
                    state_next = S_IDLE;
                end else begin
                    addr_next  = rem_reg[AW-1:0];
                    state_next = S_FETCH;
                end
            end

            S_FETCH: begin
                // issue one read per cycle; the data is captured in the following cycle
                if (ic_reg < nb) begin
                    addr_next = (addr_reg == AW'(MEM_BYTES - 1)) ? '0
                                                                 : addr_reg + AW'(1);
                    ic_next   = ic_reg + 4'd1;
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    acc_next[{pos, 3'b000} +: 8] = rd_data_reg;
                    cc_next = cc_reg + 4'd1;
                end
                if ((cc_reg == nb) && !pend_reg && out_free) begin
                    emit       = 1'b1;
                    res_found  = 1'b1;
                    res_value  = fin_value;
                    res_type   = fin_type;
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ic_reg    <= '0;
            cc_reg    <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ic_reg    <= ic_next;
            cc_reg    <= cc_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        byte_reg  <= byte_next;
        row_reg   <= row_next;
        r_reg     <= r_next;
        width_reg <= width_next;
        src_reg   <= src_next;
        rem_reg   <= rem_next;
        op_reg    <= op_next;
        addr_reg  <= addr_next;
        acc_reg   <= acc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_found_reg <= res_found;
            m_value_reg <= res_value;
            m_type_reg  <= res_type;
        end
    end

    // checks
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(SRC_W))
        else $error("step counter beyond unit length");

    a_fetch_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FETCH) |-> (cc_reg <= ic_reg) && (ic_reg <= nb))
        else $error("byte capture ahead of issue or past element size");

    a_nil_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> (m_value_reg == '0) && (m_type_reg == VT_INT))
        else $error("nil result carries data");

    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_kind == KIND_READ)) |=> !s_tready)
        else $error("read accepted but block still ready");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> out_free)
        else $error("result overwrote a pending word");

endmodule
